>>> rtl/nnc_pkg.sv
// Shared types, constants and helpers for the nearest-neighbor classifier.
`timescale 1ns / 1ps

package nnc_pkg;

  localparam int DEF_MAX_TRAIN    = 64;
  localparam int DEF_MAX_FEATURES = 64;

  localparam int FEAT_W  = 16;
  localparam int DIFF_W  = FEAT_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = 40;
  localparam int LABEL_W = 8;
  localparam int COUNT_W = 7;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  localparam logic [COUNT_W-1:0] TRAIN_COUNT_RESET = 7'd1;

  typedef struct packed {
    logic                     cmd;
    logic [5:0]               train_slot;
    logic [5:0]               feature_index;
    logic signed [FEAT_W-1:0] feature_value;
    logic [LABEL_W-1:0]       class_label;
    logic                     last_feature;
  } nnc_in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] predicted_label;
    logic [5:0]         nearest_index;
    logic [SUM_W-1:0]   squared_distance;
  } nnc_out_t;

  // Control from the sequencer to the distance datapath.
  typedef struct packed {
    logic load_we;
    logic issue;
    logic first;
    logic add_en;
    logic clear_all;
  } nnc_ctrl_t;

  function automatic int idx_w(input int depth);
    idx_w = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

>>> rtl/nearest_neighbor_classify.sv
// Top level of the one-nearest-neighbor classifier: sequencer, labels, config and result register.
`timescale 1ns / 1ps
//
// Input items arrive on in_valid/in_stall/in_data. A load item (cmd 0) writes one
// training feature and the slot's label without leaving idle. A test item (cmd 1)
// sweeps the active training vectors, slots 0 to n-1 where n is train_count
// (0 reads as 1, values above MAX_TRAIN as MAX_TRAIN), through one shared
// subtract-square-accumulate unit, one slot per cycle. After the sweep the block
// waits in a drain state until the accumulate pipeline is empty; an item flagged
// last_feature then reads the winning slot's label and loads the result register.
// in_stall is high for the whole time a test item is at work. The result register
// holds one item; if the receiver stalls, a finished result waits there and the
// block keeps taking items, and only a further last item waits before it finishes.
// cfg_we/cfg_wdata set train_count, to be written while idle (the block does not
// enforce this). Synchronous reset sets train_count to 1, clears all accumulators
// and the result valid bit; training features and labels are undefined until loaded.

module nearest_neighbor_classify #(
  parameter int MAX_TRAIN    = nnc_pkg::DEF_MAX_TRAIN,
  parameter int MAX_FEATURES = nnc_pkg::DEF_MAX_FEATURES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  nnc_pkg::nnc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output nnc_pkg::nnc_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [nnc_pkg::COUNT_W-1:0]   cfg_wdata
);

  localparam int TW      = nnc_pkg::idx_w(MAX_TRAIN);
  localparam int AW      = nnc_pkg::idx_w(MAX_TRAIN * MAX_FEATURES);
  localparam int CW      = $clog2(MAX_TRAIN + 1);
  localparam int FEAT_W  = nnc_pkg::FEAT_W;
  localparam int SUM_W   = nnc_pkg::SUM_W;
  localparam int LABEL_W = nnc_pkg::LABEL_W;
  localparam int COUNT_W = nnc_pkg::COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SWEEP = 5'b00010,
    S_DRAIN = 5'b00100,
    S_LABEL = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [TW-1:0]            t_r, t_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [CW-1:0]            n_r, n_nxt;
  logic signed [FEAT_W-1:0] value_r;
  logic                     last_r, add_en_r;
  logic [COUNT_W-1:0]       train_count_r;
  logic                     out_valid_r;
  nnc_pkg::nnc_out_t        out_data_r;
  logic [LABEL_W-1:0]       label_mem [MAX_TRAIN];
  logic [LABEL_W-1:0]       label_rd_r;

  logic                     in_accept, load_ok, fidx_ok, out_free, out_load, sweep_end;
  logic [AW-1:0]            load_addr, feat_addr;
  nnc_pkg::nnc_ctrl_t       ctrl;
  logic                     dp_busy;
  logic [TW-1:0]            best_idx;
  logic [SUM_W-1:0]         best_sum;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign fidx_ok   = (32'(in_data.feature_index) < MAX_FEATURES);
  assign load_ok   = fidx_ok && (32'(in_data.train_slot) < MAX_TRAIN);
  assign load_addr = AW'(32'(in_data.train_slot) * MAX_FEATURES + 32'(in_data.feature_index));
  assign feat_addr = (state_r == S_IDLE) ? load_addr : addr_r;
  assign sweep_end = ((CW+1)'((CW+1)'(t_r) + 1'b1) == (CW+1)'(n_r));
  assign out_free  = !out_valid_r || !out_stall;

  // Active vector count taken from the register when a test item starts.
  always_comb begin
    priority if (train_count_r == '0) begin
      n_nxt = CW'(1);
    end else if (32'(train_count_r) > MAX_TRAIN) begin
      n_nxt = CW'(MAX_TRAIN);
    end else begin
      n_nxt = CW'(train_count_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    t_nxt          = t_r;
    addr_nxt       = addr_r;
    out_load       = 1'b0;
    ctrl           = '0;
    ctrl.load_we   = in_accept && (in_data.cmd == nnc_pkg::CMD_LOAD) && load_ok;
    ctrl.issue     = (state_r == S_SWEEP);
    ctrl.first     = (t_r == '0);
    ctrl.add_en    = add_en_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (in_data.cmd == nnc_pkg::CMD_TEST)) begin
          state_nxt = S_SWEEP;
          t_nxt     = '0;
          addr_nxt  = AW'(in_data.feature_index);
        end
      end
      S_SWEEP: begin
        t_nxt    = TW'(t_r + 1'b1);
        addr_nxt = AW'(addr_r + AW'(MAX_FEATURES));
        if (sweep_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!dp_busy) begin
          if (last_r) begin
            state_nxt      = S_LABEL;
            ctrl.clear_all = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LABEL: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      train_count_r <= nnc_pkg::TRAIN_COUNT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        train_count_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    addr_r <= addr_nxt;
    if (in_accept && (in_data.cmd == nnc_pkg::CMD_TEST)) begin
      n_r      <= n_nxt;
      value_r  <= in_data.feature_value;
      last_r   <= in_data.last_feature;
      add_en_r <= fidx_ok;
    end
    if (out_load) begin
      out_data_r.predicted_label  <= label_rd_r;
      out_data_r.nearest_index    <= 6'(best_idx);
      out_data_r.squared_distance <= best_sum;
    end
  end

  // Label memory; the read follows the winning slot once the sweep has drained.
  always_ff @(posedge clk) begin
    if (ctrl.load_we) begin
      label_mem[TW'(in_data.train_slot)] <= in_data.class_label;
    end
    label_rd_r <= label_mem[best_idx];
  end

  nnc_datapath #(
    .MAX_TRAIN    (MAX_TRAIN),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .feat_addr  (feat_addr),
    .slot       (t_r),
    .load_value (in_data.feature_value),
    .test_value (value_r),
    .busy       (dp_busy),
    .best_idx   (best_idx),
    .best_sum   (best_sum)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> ((CW+1)'(t_r) < (CW+1)'(n_r)))
    else $error("sweep slot beyond the active count");

  a_drained_before_label: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LABEL) |-> !dp_busy)
    else $error("result taken before the accumulate pipeline drained");

  a_result_from_sequencer: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_HOLD))
    else $error("result appeared outside the result state");

endmodule

>>> rtl/nnc_datapath.sv
// Feature and accumulator memories with the shared square-accumulate unit and minimum tracker.
`timescale 1ns / 1ps

module nnc_datapath #(
  parameter int MAX_TRAIN    = nnc_pkg::DEF_MAX_TRAIN,
  parameter int MAX_FEATURES = nnc_pkg::DEF_MAX_FEATURES
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  nnc_pkg::nnc_ctrl_t                            ctrl,
  input  logic [nnc_pkg::idx_w(MAX_TRAIN*MAX_FEATURES)-1:0] feat_addr,
  input  logic [nnc_pkg::idx_w(MAX_TRAIN)-1:0]          slot,
  input  logic signed [nnc_pkg::FEAT_W-1:0]             load_value,
  input  logic signed [nnc_pkg::FEAT_W-1:0]             test_value,
  output logic                                          busy,
  output logic [nnc_pkg::idx_w(MAX_TRAIN)-1:0]          best_idx,
  output logic [nnc_pkg::SUM_W-1:0]                     best_sum
);

  localparam int TW     = nnc_pkg::idx_w(MAX_TRAIN);
  localparam int DEPTH  = MAX_TRAIN * MAX_FEATURES;
  localparam int FEAT_W = nnc_pkg::FEAT_W;
  localparam int DIFF_W = nnc_pkg::DIFF_W;
  localparam int PROD_W = nnc_pkg::PROD_W;
  localparam int SUM_W  = nnc_pkg::SUM_W;

  logic signed [FEAT_W-1:0] feat_mem [DEPTH];
  logic [SUM_W-1:0]         sum_mem  [MAX_TRAIN];
  logic [MAX_TRAIN-1:0]     vld_r;

  logic signed [FEAT_W-1:0] feat_rd_r;
  logic [SUM_W-1:0]         sum_rd_r;
  logic                     vld_rd_r;

  logic                     s1_v_r, s1_first_r, s1_add_r;
  logic [TW-1:0]            s1_slot_r;
  logic                     s2_v_r, s2_first_r;
  logic [TW-1:0]            s2_slot_r;
  logic [PROD_W-1:0]        prod_r;
  logic [SUM_W-1:0]         sum2_r;

  logic [TW-1:0]            best_idx_r;
  logic [SUM_W-1:0]         best_sum_r;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] sq;
  logic [SUM_W:0]           total;
  logic [SUM_W-1:0]         new_sum;

  // Single-ported feature memory: loads and sweeps never overlap.
  always_ff @(posedge clk) begin
    if (ctrl.load_we) begin
      feat_mem[feat_addr] <= load_value;
    end
    feat_rd_r <= feat_mem[feat_addr];
  end

  // Accumulator memory: read for slot t while slot t-2 is written back.
  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      sum_mem[s2_slot_r] <= new_sum;
    end
    sum_rd_r <= sum_mem[slot];
    vld_rd_r <= vld_r[slot];
  end

  // An accumulator without its valid bit reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctrl.clear_all) begin
      vld_r <= '0;
    end else if (s2_v_r) begin
      vld_r[s2_slot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= ctrl.issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_comb begin
    diff = {test_value[FEAT_W-1], test_value} - {feat_rd_r[FEAT_W-1], feat_rd_r};
    sq   = diff * diff;
  end

  always_ff @(posedge clk) begin
    s1_slot_r  <= slot;
    s1_first_r <= ctrl.first;
    s1_add_r   <= ctrl.add_en;
    s2_slot_r  <= s1_slot_r;
    s2_first_r <= s1_first_r;
    prod_r     <= s1_add_r ? PROD_W'(unsigned'(sq)) : '0;
    sum2_r     <= vld_rd_r ? sum_rd_r : '0;
  end

  always_comb begin
    total   = {1'b0, sum2_r} + (SUM_W+1)'(prod_r);
    new_sum = total[SUM_W] ? '1 : total[SUM_W-1:0];
  end

  // Strictly smaller wins, so the lowest slot keeps a tie.
  always_ff @(posedge clk) begin
    if (s2_v_r && (s2_first_r || (new_sum < best_sum_r))) begin
      best_sum_r <= new_sum;
      best_idx_r <= s2_slot_r;
    end
  end

  assign busy     = s1_v_r | s2_v_r;
  assign best_idx = best_idx_r;
  assign best_sum = best_sum_r;

endmodule
